>>> rtl/core/cbrf_pkg.sv
// ----------------------------------------------------------------------------
// cbrf_pkg
// Shared types and constants of the cubic bisection root finder.
// ----------------------------------------------------------------------------
`default_nettype none

package cbrf_pkg;

    localparam int MAX_ITER = 10;
    localparam int STEP_W   = $clog2(MAX_ITER + 1);
    localparam int X_W      = 24;
    localparam int COEF_W   = 8;
    localparam int TOL_W    = 23;
    localparam int PIPE_W   = 84;
    localparam int DIGIT_W  = 8;
    localparam int NUM_DIG  = 3;
    localparam int NUM_CELL = 3 * NUM_DIG;

    localparam logic [2:0] ST_ROW   = 3'd0;
    localparam logic [2:0] ST_TOL   = 3'd1;
    localparam logic [2:0] ST_MIDZ  = 3'd2;
    localparam logic [2:0] ST_ENDR  = 3'd3;
    localparam logic [2:0] ST_NOSGN = 3'd4;
    localparam logic [2:0] ST_BAD   = 3'd5;
    localparam logic [2:0] ST_LIMIT = 3'd6;

    localparam logic [2:0] REG_CUBIC  = 3'd0;
    localparam logic [2:0] REG_SQUARE = 3'd1;
    localparam logic [2:0] REG_LINEAR = 3'd2;
    localparam logic [2:0] REG_CONST  = 3'd3;
    localparam logic [2:0] REG_TOL    = 3'd4;

    typedef struct packed {
        logic                     valid;
        logic signed [X_W-1:0]    x;
        logic signed [PIPE_W-1:0] t;
        logic signed [PIPE_W-1:0] acc;
    } t_cell;

endpackage

`default_nettype wire

>>> rtl/core/cbrf_cell.sv
// ----------------------------------------------------------------------------
// cbrf_cell
// One multiply-accumulate cell of the Horner chain: adds one 8-bit digit
// product of x to the running sum and closes a Horner step on the top digit.
// ----------------------------------------------------------------------------
`default_nettype none

module cbrf_cell (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic [1:0]                       i_pos,
    input  wire logic signed [cbrf_pkg::PIPE_W-1:0] i_addend,
    input  wire cbrf_pkg::t_cell                  i_cell,
    output cbrf_pkg::t_cell                       o_cell
);
    import cbrf_pkg::*;

    logic signed [DIGIT_W:0]        digit;
    logic signed [PIPE_W+DIGIT_W:0] prod;
    logic signed [PIPE_W-1:0]       shifted;
    logic signed [PIPE_W-1:0]       sum;
    t_cell                          r_cell;

    always_comb begin
        case (i_pos)
            2'd0:    digit = {1'b0, i_cell.x[7:0]};
            2'd1:    digit = {1'b0, i_cell.x[15:8]};
            2'd2:    digit = {i_cell.x[23], i_cell.x[23:16]};
            default: digit = '0;
        endcase
        prod    = i_cell.t * digit;
        shifted = PIPE_W'(prod) <<< (DIGIT_W * int'(i_pos));
        sum     = i_cell.acc + shifted;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else begin
            r_cell.valid <= i_cell.valid;
        end
        r_cell.x <= i_cell.x;
        if (i_pos == 2'd2) begin
            r_cell.t   <= sum + i_addend;
            r_cell.acc <= '0;
        end else begin
            r_cell.t   <= i_cell.t;
            r_cell.acc <= sum;
        end
    end

    assign o_cell = r_cell;

endmodule

`default_nettype wire

>>> rtl/core/cubic_bisection_root_finder.sv
// ----------------------------------------------------------------------------
// cubic_bisection_root_finder
// Bisection search for a root of a cubic with programmable integer
// coefficients over a signed Q8.16 interval.
// ----------------------------------------------------------------------------
// Usage: an input word is an interval (start_low, start_high). The block
// answers with one output word per bisection row, the final one with last
// set and a status code. Coefficients and tolerance are to be written through the
// plain write port while the block is idle; the block does not enforce this.
// The polynomial sign is found by a chain of nine multiply-accumulate cells,
// three per Horner step, each taking one 8-bit digit of x; every cell holds
// a register. Row one needs two evaluations, of the low and the high end;
// each later row needs one evaluation of the new midpoint, fed as the word
// of the row before is loaded into the output register. A bad interval
// (high end not above low end) is answered with a single word.
// One interval is worked at a time: o_in_stall is high from acceptance until
// the last word has been loaded into the output register.
// A stalled output word holds; the search waits until it is taken.
// Reset (synchronous, active low) restores the default coefficients and
// tolerance and empties the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cubic_bisection_root_finder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [22:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic signed [23:0] i_start_low,
    input  wire logic signed [23:0] i_start_high,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [3:0]       o_iteration,
    output logic signed [23:0] o_low_end,
    output logic signed [23:0] o_high_end,
    output logic signed [23:0] o_midpoint,
    output logic [23:0]      o_error_bound,
    output logic [2:0]       o_status,
    output logic             o_last
);
    import cbrf_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FEEDH = 3'd1;
    localparam logic [2:0] S_WAIT2 = 3'd2;
    localparam logic [2:0] S_EMIT  = 3'd3;
    localparam logic [2:0] S_WAITM = 3'd4;

    logic [2:0]                r_state;
    logic signed [COEF_W-1:0]  r_coef_cubic, r_coef_square, r_coef_linear, r_coef_const;
    logic [TOL_W-1:0]          r_tol;
    logic signed [X_W-1:0]     r_low, r_high, r_mid;
    logic                      r_low_neg;
    logic [STEP_W-1:0]         r_step;
    logic                      r_got_low, r_sl_zero, r_sl_neg;
    logic [3:0]                r_row_iter;
    logic signed [X_W-1:0]     r_row_low, r_row_high, r_row_mid;
    logic [X_W-1:0]            r_row_err;
    logic [2:0]                r_row_status;
    logic                      r_row_last;
    logic                      r_o_valid;
    logic [3:0]                r_o_iter;
    logic signed [X_W-1:0]     r_o_low, r_o_high, r_o_mid;
    logic [X_W-1:0]            r_o_err;
    logic [2:0]                r_o_status;
    logic                      r_o_last;

    logic                      feed_valid;
    logic signed [X_W-1:0]     feed_x;
    logic signed [PIPE_W-1:0]  addend [3];
    t_cell                     chain [NUM_CELL+1];
    logic                      res_zero, res_neg;
    logic                      out_free;
    logic                      out_load;
    logic                      in_acc;
    logic signed [X_W:0]       in_sum, in_diff;
    logic signed [X_W-1:0]     n_low, n_high;
    logic signed [X_W:0]       n_sum, n_diff;
    logic [X_W-1:0]            n_err;
    logic [STEP_W-1:0]         n_step;

    assign addend[0] = PIPE_W'(r_coef_square) <<< 16;
    assign addend[1] = PIPE_W'(r_coef_linear) <<< 32;
    assign addend[2] = PIPE_W'(r_coef_const) <<< 48;

    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free   = !r_o_valid || !i_out_stall;
    assign out_load   = (r_state == S_EMIT) && out_free;

    always_comb begin
        feed_valid = 1'b0;
        feed_x     = r_high;
        case (r_state)
            S_IDLE: begin
                feed_valid = in_acc && (i_start_high > i_start_low);
                feed_x     = i_start_low;
            end
            S_FEEDH: begin
                feed_valid = 1'b1;
                feed_x     = r_high;
            end
            S_EMIT: begin
                feed_valid = out_free && !r_row_last;
                feed_x     = r_mid;
            end
            default: begin
                feed_valid = 1'b0;
            end
        endcase
    end

    assign chain[0].valid = feed_valid;
    assign chain[0].x     = feed_x;
    assign chain[0].t     = PIPE_W'(r_coef_cubic);
    assign chain[0].acc   = '0;

    for (genvar k = 0; k < NUM_CELL; k++) begin : g_cell
        cbrf_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_pos    (2'(k % NUM_DIG)),
            .i_addend (addend[k / NUM_DIG]),
            .i_cell   (chain[k]),
            .o_cell   (chain[k+1])
        );
    end

    assign res_zero = (chain[NUM_CELL].t == '0);
    assign res_neg  = chain[NUM_CELL].t[PIPE_W-1];

    assign in_sum  = {i_start_low[X_W-1], i_start_low}
                     + {i_start_high[X_W-1], i_start_high};
    assign in_diff = {i_start_high[X_W-1], i_start_high}
                     - {i_start_low[X_W-1], i_start_low};

    always_comb begin
        if (res_neg != r_low_neg) begin
            n_low  = r_low;
            n_high = r_mid;
        end else begin
            n_low  = r_mid;
            n_high = r_high;
        end
        n_sum  = {n_low[X_W-1], n_low} + {n_high[X_W-1], n_high};
        n_diff = {n_high[X_W-1], n_high} - {n_low[X_W-1], n_low};
        n_err  = n_diff[X_W:1];
        n_step = r_step + STEP_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_coef_cubic  <= 8'sd2;
            r_coef_square <= -8'sd3;
            r_coef_linear <= -8'sd4;
            r_coef_const  <= 8'sd5;
            r_tol         <= 23'd66;
            r_o_valid     <= 1'b0;
            r_got_low     <= 1'b0;
            r_low         <= '0;
            r_high        <= '0;
            r_mid         <= '0;
            r_low_neg     <= 1'b0;
            r_step        <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_CUBIC:  r_coef_cubic  <= i_cfg_data[7:0];
                    REG_SQUARE: r_coef_square <= i_cfg_data[7:0];
                    REG_LINEAR: r_coef_linear <= i_cfg_data[7:0];
                    REG_CONST:  r_coef_const  <= i_cfg_data[7:0];
                    REG_TOL:    r_tol         <= i_cfg_data;
                    default:    r_tol         <= r_tol;
                endcase
            end
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_low     <= i_start_low;
                        r_high    <= i_start_high;
                        r_got_low <= 1'b0;
                        r_row_low  <= i_start_low;
                        r_row_high <= i_start_high;
                        if (i_start_high > i_start_low) begin
                            r_mid     <= in_sum[X_W:1];
                            r_row_mid <= in_sum[X_W:1];
                            r_row_err <= in_diff[X_W:1];
                            r_step    <= STEP_W'(1);
                            r_state   <= S_FEEDH;
                        end else begin
                            r_mid        <= '0;
                            r_step       <= '0;
                            r_row_iter   <= 4'd0;
                            r_row_mid    <= '0;
                            r_row_err    <= '0;
                            r_row_status <= ST_BAD;
                            r_row_last   <= 1'b1;
                            r_state      <= S_EMIT;
                        end
                    end
                end
                S_FEEDH: begin
                    r_state <= S_WAIT2;
                end
                S_WAIT2: begin
                    if (chain[NUM_CELL].valid) begin
                        if (!r_got_low) begin
                            r_got_low <= 1'b1;
                            r_sl_zero <= res_zero;
                            r_sl_neg  <= res_neg;
                            r_low_neg <= res_neg;
                        end else begin
                            r_row_iter <= 4'd1;
                            if (r_sl_zero || res_zero) begin
                                r_row_status <= ST_ENDR;
                                r_row_last   <= 1'b1;
                            end else if (r_sl_neg == res_neg) begin
                                r_row_status <= ST_NOSGN;
                                r_row_last   <= 1'b1;
                            end else begin
                                r_row_status <= ST_ROW;
                                r_row_last   <= 1'b0;
                            end
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_o_iter   <= r_row_iter;
                        r_o_low    <= r_row_low;
                        r_o_high   <= r_row_high;
                        r_o_mid    <= r_row_mid;
                        r_o_err    <= r_row_err;
                        r_o_status <= r_row_status;
                        r_o_last   <= r_row_last;
                        r_state    <= r_row_last ? S_IDLE : S_WAITM;
                    end
                end
                S_WAITM: begin
                    if (chain[NUM_CELL].valid) begin
                        r_step     <= n_step;
                        r_row_iter <= 4'(n_step);
                        r_state    <= S_EMIT;
                        if (res_zero) begin
                            r_row_low    <= r_low;
                            r_row_high   <= r_high;
                            r_row_mid    <= r_mid;
                            r_row_err    <= r_row_err;
                            r_row_status <= ST_MIDZ;
                            r_row_last   <= 1'b1;
                        end else begin
                            r_low      <= n_low;
                            r_high     <= n_high;
                            r_mid      <= n_sum[X_W:1];
                            r_row_low  <= n_low;
                            r_row_high <= n_high;
                            r_row_mid  <= n_sum[X_W:1];
                            r_row_err  <= n_err;
                            if (n_err <= {1'b0, r_tol}) begin
                                r_row_status <= ST_TOL;
                                r_row_last   <= 1'b1;
                            end else if (n_step == STEP_W'(MAX_ITER)) begin
                                r_row_status <= ST_LIMIT;
                                r_row_last   <= 1'b1;
                            end else begin
                                r_row_status <= ST_ROW;
                                r_row_last   <= 1'b0;
                            end
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid   = r_o_valid;
    assign o_iteration   = r_o_iter;
    assign o_low_end     = r_o_low;
    assign o_high_end    = r_o_high;
    assign o_midpoint    = r_o_mid;
    assign o_error_bound = r_o_err;
    assign o_status      = r_o_status;
    assign o_last        = r_o_last;

endmodule

`default_nettype wire
